/* hdl/sqd_pkg.sv */
// ============================================================================
// sqd_pkg - shared types and constants for the shortest-queue dispatcher
// Field widths, status and kind codes, the controller state type and the
// update command that the controller sends along the row of server cells.
// ============================================================================
package sqd_pkg;

    // Fixed field widths of the stream beats.
    localparam int ID_W      = 10;
    localparam int SRV_W     = 3;
    localparam int QSEL_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 4;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Server index carried by an update command, and the width of a server count.
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam logic KIND_ARRIVAL   = 1'b0;
    localparam logic KIND_DEPARTURE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CFG_W-1:0] NUM_SERVERS_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEPART,
        ST_READ,
        ST_RESULT
    } state_t;

    // Push appends one entry to a queue; pop removes its head.
    typedef struct packed {
        logic             valid;
        logic             pop;
        logic [IDX_W-1:0] idx;
    } upd_t;

endpackage

/* hdl/shortest_queue_dispatch.sv */
// ============================================================================
// shortest_queue_dispatch - join-shortest-queue dispatcher
// Keeps one FIFO of requester IDs per server. Arrivals join the shortest
// enabled queue, departures pop the head of the named queue, and every
// input beat gives exactly one result beat.
// ============================================================================
//
//  Channel   Direction  Signals                         Contents
//  --------  ---------  ------------------------------  ---------------------------
//  s_        in         s_tvalid s_tready s_tdata s_tuser  event: kind, id, server
//  m_        out        m_tvalid m_tready m_tdata          result of one event
//  cfg_      in         cfg_wr_en cfg_wr_data              num_servers register
//
//  For an arrival the search wave walks the row of server cells one cell per
//  cycle; the result register loads as the wave leaves the row. A departure
//  loads it in ST_DEPART, and in ST_READ when the next head is read from
//  the queue memory. The next beat is taken the cycle after the output loads.
//  After reset all queues are empty and num_servers is 8; the queue memory
//  needs no clearing pass. The input is accepted while a finished result
//  still waits in the output register; only a second result stalls on it.
//
// The queues live in one memory of SERVERS * QUEUE_DEPTH entries; each
// server cell keeps the ring head and the length of its own queue. For an
// arrival the controller injects a search wave at the first cell, which takes
// it; each later cell keeps the wave's best (index, length) pair or replaces
// it with its own when enabled and strictly shorter. Every cell registers the
// pair for its right neighbor. Once the wave leaves the last cell, if the
// chosen queue is not full the ID goes to its tail and that cell gets a push.
// ============================================================================
module shortest_queue_dispatch #(
    parameter int SERVERS     = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Event beat.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, low bit up: requester_id[9:0], server[12:10], zero pad[15:13].
    input  logic [sqd_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: kind (0 arrival, 1 departure).
    input  logic                              s_tuser,
    // Result beat.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, low bit up: chosen_queue[2:0], start_service[3],
    // started_id[13:4], status[15:14].
    output logic [sqd_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration: num_servers.
    input  logic                              cfg_wr_en,
    input  logic [sqd_pkg::CFG_W-1:0]         cfg_wr_data
);
    import sqd_pkg::*;

    localparam int SIW   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int AW    = $clog2(SERVERS * QUEUE_DEPTH);
    localparam int DEPTH = SERVERS * QUEUE_DEPTH;
    // Stored ID width: IDs are masked to ID_BITS, and never exceed the port.
    localparam int SW    = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    num_servers_reg;
    logic [CNT_W-1:0]    active_cnt;

    logic [ID_W-1:0]     id_reg;
    logic [SRV_W-1:0]    srv_reg;

    logic [QSEL_W-1:0]   res_queue_reg, res_queue_next;
    logic                res_start_reg, res_start_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_load;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                out_load;

    logic [SW-1:0]       store_mem [DEPTH];
    logic [SW-1:0]       mem_rdata_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_addr;

    logic                s_accept;
    logic                scan_start;
    upd_t                upd;

    // Search wave links: entry k feeds cell k, entry SERVERS leaves the row.
    logic                wave_valid [SERVERS+1];
    logic [SIW-1:0]      wave_idx   [SERVERS+1];
    logic [LW-1:0]       wave_len   [SERVERS+1];
    logic [LW-1:0]       len_w      [SERVERS];
    logic [PW-1:0]       head_w     [SERVERS];

    // Arrival side, evaluated as the wave leaves the last cell.
    logic [SIW-1:0]      best_idx;
    logic [LW-1:0]       best_len;
    logic                best_full;
    logic [PW:0]         tail_sum;
    logic [PW-1:0]       tail_ptr;

    // Departure side.
    logic [SIW-1:0]      dep_idx;
    logic                dep_ok;
    logic                dep_more;
    logic [PW-1:0]       dep_head;
    logic [PW-1:0]       dep_next_head;

    // Out-of-range server counts fold into 1..SERVERS.
    always_comb begin
        if (num_servers_reg == '0) begin
            active_cnt = CNT_W'(1);
        end else if (CNT_W'(num_servers_reg) > CNT_W'(SERVERS)) begin
            active_cnt = CNT_W'(SERVERS);
        end else begin
            active_cnt = CNT_W'(num_servers_reg);
        end
    end

    assign s_accept = s_tvalid && s_tready;

    assign wave_valid[0] = scan_start;
    assign wave_idx[0]   = '0;
    assign wave_len[0]   = '0;

    for (genvar k = 0; k < SERVERS; k++) begin : g_cell
        sqd_cell #(
            .INDEX       (k),
            .SERVERS     (SERVERS),
            .QUEUE_DEPTH (QUEUE_DEPTH)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .upd            (upd),
            .active_cnt     (active_cnt),
            .wave_in_valid  (wave_valid[k]),
            .wave_in_idx    (wave_idx[k]),
            .wave_in_len    (wave_len[k]),
            .wave_out_valid (wave_valid[k+1]),
            .wave_out_idx   (wave_idx[k+1]),
            .wave_out_len   (wave_len[k+1]),
            .len_o          (len_w[k]),
            .head_o         (head_w[k])
        );
    end

    // Tail of the chosen queue: head plus length, wrapped once around the ring.
    assign best_idx  = wave_idx[SERVERS];
    assign best_len  = wave_len[SERVERS];
    assign best_full = best_len >= LW'(QUEUE_DEPTH);
    assign tail_sum  = (PW+1)'(head_w[best_idx]) + (PW+1)'(best_len);
    assign tail_ptr  = (tail_sum >= (PW+1)'(QUEUE_DEPTH))
                     ? PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);

    // A departure naming a server that does not exist counts as empty.
    assign dep_idx       = SIW'(srv_reg);
    assign dep_ok        = (CNT_W'(srv_reg) < CNT_W'(SERVERS)) && (len_w[dep_idx] != '0);
    assign dep_more      = len_w[dep_idx] > LW'(1);
    assign dep_head      = head_w[dep_idx];
    assign dep_next_head = (dep_head == PW'(QUEUE_DEPTH - 1)) ? '0 : dep_head + PW'(1);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == KIND_ARRIVAL) ? ST_SCAN : ST_DEPART;
                end
            end
            ST_SCAN: begin
                if (wave_valid[SERVERS]) begin
                    state_next = ST_RESULT;
                end
            end
            ST_DEPART: begin
                state_next = (dep_ok && dep_more) ? ST_READ : ST_RESULT;
            end
            ST_READ: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb begin
        s_tready        = 1'b0;
        scan_start      = 1'b0;
        upd             = '0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = '0;
        res_load        = 1'b0;
        out_load        = 1'b0;
        res_queue_next  = res_queue_reg;
        res_start_next  = res_start_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // No beat is taken while reset is held.
                s_tready   = aresetn;
                scan_start = s_accept && (s_tuser == KIND_ARRIVAL);
            end
            ST_SCAN: begin
                if (wave_valid[SERVERS]) begin
                    res_load       = 1'b1;
                    res_queue_next = QSEL_W'(best_idx);
                    if (best_full) begin
                        res_start_next  = 1'b0;
                        res_id_next     = '0;
                        res_status_next = STATUS_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_addr  = AW'(AW'(best_idx) * AW'(QUEUE_DEPTH) + AW'(tail_ptr));
                        upd.valid = 1'b1;
                        upd.pop   = 1'b0;
                        upd.idx   = IDX_W'(best_idx);
                        // An empty queue means the arrival goes straight into service.
                        res_start_next  = (best_len == '0);
                        res_id_next     = (best_len == '0) ? ID_W'(SW'(id_reg)) : '0;
                        res_status_next = STATUS_OK;
                    end
                end
            end
            ST_DEPART: begin
                res_load        = 1'b1;
                res_queue_next  = srv_reg;
                res_start_next  = 1'b0;
                res_id_next     = '0;
                res_status_next = dep_ok ? STATUS_OK : STATUS_EMPTY;
                if (dep_ok) begin
                    upd.valid = 1'b1;
                    upd.pop   = 1'b1;
                    upd.idx   = IDX_W'(dep_idx);
                    if (dep_more) begin
                        mem_re         = 1'b1;
                        mem_addr       = AW'(AW'(dep_idx) * AW'(QUEUE_DEPTH) + AW'(dep_next_head));
                        res_start_next = 1'b1;
                    end
                end
            end
            ST_READ: begin
                res_load    = 1'b1;
                res_id_next = ID_W'(mem_rdata_reg);
            end
            ST_RESULT: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            num_servers_reg <= NUM_SERVERS_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                num_servers_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            id_reg  <= s_tdata[ID_W-1:0];
            srv_reg <= s_tdata[ID_W +: SRV_W];
        end
        if (res_load) begin
            res_queue_reg  <= res_queue_next;
            res_start_reg  <= res_start_next;
            res_id_reg     <= res_id_next;
            res_status_reg <= res_status_next;
        end
        if (out_load) begin
            m_tdata_reg <= {res_status_reg, res_id_reg, res_start_reg, res_queue_reg};
        end
    end

    // Queue memory: at most one write or one registered read per event.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_addr] <= SW'(id_reg);
        end
        if (mem_re) begin
            mem_rdata_reg <= store_mem[mem_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hdl/sqd_cell.sv */
// ============================================================================
// sqd_cell - one server's queue bookkeeping
// Holds the head pointer and length of one queue, applies push and pop
// commands, and passes the shortest-queue search wave on to its neighbor.
// ============================================================================
module sqd_cell #(
    parameter int INDEX       = 0,
    parameter int SERVERS     = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  sqd_pkg::upd_t                             upd,
    input  logic [sqd_pkg::CNT_W-1:0]                 active_cnt,
    input  logic                                      wave_in_valid,
    input  logic [(SERVERS > 1 ? $clog2(SERVERS) : 1)-1:0] wave_in_idx,
    input  logic [$clog2(QUEUE_DEPTH + 1)-1:0]        wave_in_len,
    output logic                                      wave_out_valid,
    output logic [(SERVERS > 1 ? $clog2(SERVERS) : 1)-1:0] wave_out_idx,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]        wave_out_len,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]        len_o,
    output logic [$clog2(QUEUE_DEPTH)-1:0]            head_o
);
    import sqd_pkg::*;

    localparam int SIW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = $clog2(QUEUE_DEPTH);

    logic [LW-1:0]  len_reg, len_next;
    logic [PW-1:0]  head_reg, head_next;
    logic           wave_valid_reg;
    logic [SIW-1:0] wave_idx_reg, wave_idx_next;
    logic [LW-1:0]  wave_len_reg, wave_len_next;
    logic           hit;
    logic           enabled;
    logic           take;

    assign hit     = upd.valid && (upd.idx == IDX_W'(INDEX));
    assign enabled = CNT_W'(INDEX) < active_cnt;
    // The first cell always claims the wave; later cells claim it only when
    // strictly shorter, so ties stay with the lower index.
    assign take    = enabled && ((INDEX == 0) || (len_reg < wave_in_len));

    always_comb begin
        len_next  = len_reg;
        head_next = head_reg;
        if (hit) begin
            if (upd.pop) begin
                len_next  = len_reg - LW'(1);
                head_next = (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PW'(1);
            end else begin
                len_next = len_reg + LW'(1);
            end
        end
    end

    always_comb begin
        wave_idx_next = take ? SIW'(INDEX) : wave_in_idx;
        wave_len_next = take ? len_reg : wave_in_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            head_reg       <= '0;
            wave_valid_reg <= 1'b0;
        end else begin
            len_reg        <= len_next;
            head_reg       <= head_next;
            wave_valid_reg <= wave_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        wave_idx_reg <= wave_idx_next;
        wave_len_reg <= wave_len_next;
    end

    assign wave_out_valid = wave_valid_reg;
    assign wave_out_idx   = wave_idx_reg;
    assign wave_out_len   = wave_len_reg;
    assign len_o          = len_reg;
    assign head_o         = head_reg;

endmodule
